>>> rtl/core/sbfr_pkg.sv
package sbfr_pkg;

	localparam int FRAME_BYTES   = 25;
	localparam int CHANNEL_COUNT = 16;
	localparam int CHAN_BITS     = 11;
	localparam int DATA_BYTES    = CHANNEL_COUNT * CHAN_BITS / 8;
	localparam int DATA_BITS     = DATA_BYTES * 8;
	localparam int CNT_W         = 5;
	localparam int IDX_W         = 4;
	localparam int VALUE_W       = 12;
	localparam int TIME_W        = 32;
	localparam int MAG_W         = 21;
	localparam int MULB_W        = 11;
	localparam int PROD_W        = 32;
	localparam int RECIP_SHIFT   = 21;
	localparam int QUO_W         = 11;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_BYTE = 8'h00;

	localparam logic [CHAN_BITS-1:0] CHAN_OFFSET = 11'd173;
	localparam logic [MULB_W-1:0]    SCALE_MUL   = 11'd1020;
	localparam logic [MULB_W-1:0]    SCALE_DIV   = 11'd1638;
	// floor(2**RECIP_SHIFT / SCALE_DIV); the estimate is low by at most one.
	localparam logic [MULB_W-1:0]    RECIP_MUL   = 11'd1280;
	localparam logic [VALUE_W-1:0]   CHAN_CENTER = 12'd990;

	localparam logic [7:0]  GAP_RESET   = 8'd5;
	localparam logic [7:0]  STUCK_RESET = 8'd6;
	localparam logic [15:0] RXTO_RESET  = 16'd125;

	localparam logic CMD_BYTE     = 1'b0;
	localparam logic CMD_TICK     = 1'b1;
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_START_GAP       = 2'd0,
		CFG_STUCK_TIMEOUT   = 2'd1,
		CFG_RECEIVE_TIMEOUT = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_STAT,
		ST_CH_START,
		ST_CH_WAIT,
		ST_CH_EMIT
	} rx_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MAG,
		SC_EST,
		SC_QUO,
		SC_FIX
	} scale_state_t;

	typedef struct packed {
		logic                 start;
		logic [CHAN_BITS-1:0] raw;
	} scale_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] value;
	} scale_rsp_t;

endpackage

>>> rtl/core/sbfr_scale.sv
module sbfr_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbfr_pkg::scale_req_t req,
	output sbfr_pkg::scale_rsp_t rsp
);
	import sbfr_pkg::*;

	scale_state_t         state_q, state_d;
	logic                 neg_q;
	logic [CHAN_BITS-1:0] diff_q;
	logic [MAG_W-1:0]     mag_q;
	logic [QUO_W-1:0]     quo_q;
	logic [PROD_W-1:0]    prod_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 done_q;

	logic [MAG_W-1:0]     mul_a;
	logic [MULB_W-1:0]    mul_b;
	logic [PROD_W-1:0]    prod;
	logic [MAG_W-1:0]     rem;
	logic [QUO_W-1:0]     quo_fix;

	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: begin
				if (req.start) begin
					state_d = SC_MAG;
				end
			end
			SC_MAG:  state_d = SC_EST;
			SC_EST:  state_d = SC_QUO;
			SC_QUO:  state_d = SC_FIX;
			SC_FIX:  state_d = SC_IDLE;
			default: state_d = SC_IDLE;
		endcase
	end

	// One multiplier serves the scale, the reciprocal estimate and the check.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			SC_MAG: begin
				mul_a = MAG_W'(diff_q);
				mul_b = SCALE_MUL;
			end
			SC_EST: begin
				mul_a = prod_q[MAG_W-1:0];
				mul_b = RECIP_MUL;
			end
			SC_QUO: begin
				mul_a = MAG_W'(prod_q[RECIP_SHIFT +: QUO_W]);
				mul_b = SCALE_DIV;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign rem     = mag_q - prod_q[MAG_W-1:0];
	assign quo_fix = quo_q + QUO_W'(rem >= MAG_W'(SCALE_DIV));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SC_FIX);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		if (state_q == SC_IDLE && req.start) begin
			neg_q  <= (req.raw < CHAN_OFFSET);
			diff_q <= (req.raw < CHAN_OFFSET) ? (CHAN_OFFSET - req.raw)
			                                  : (req.raw - CHAN_OFFSET);
		end
		if (state_q == SC_EST) begin
			mag_q <= prod_q[MAG_W-1:0];
		end
		if (state_q == SC_QUO) begin
			quo_q <= prod_q[RECIP_SHIFT +: QUO_W];
		end
		if (state_q == SC_FIX) begin
			value_q <= neg_q ? (CHAN_CENTER - VALUE_W'(quo_fix))
			                 : (CHAN_CENTER + VALUE_W'(quo_fix));
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

>>> rtl/core/sbus_frame_receiver.sv
// Byte transfers produce no result.
// A tick produces one status result.
// A good footer byte starts decoding the sixteen channels one at a time, each through
// the shared multiplier, which the scaler uses three times per channel.
// No input is taken while a tick or a frame decode is in progress.
// Asynchronous active-low reset clears time, frame state and configuration registers to defaults.
module sbus_frame_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  logic                             s_tuser,   // [0] cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [3:0] channel_index, [15:4] channel_value, [16] receiving, [23:17] zero
	output logic [23:0]                      m_tdata,
	output logic                             m_tuser,   // [0] kind
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sbfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbfr_pkg::*;

	rx_state_t            state_q, state_d;
	logic                 in_frame_q;
	logic [CNT_W-1:0]     byte_cnt_q;
	logic [DATA_BITS-1:0] chan_sr_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    start_q;
	logic [TIME_W-1:0]    end_q;
	logic [7:0]           gap_q;
	logic [7:0]           stuck_q;
	logic [15:0]          rxto_q;
	logic [IDX_W-1:0]     ch_idx_q;

	logic                 m_valid_q;
	logic                 out_kind_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [VALUE_W-1:0]   out_value_q;
	logic                 out_recv_q;
	logic                 out_last_q;

	scale_req_t           scl_req;
	scale_rsp_t           scl_rsp;

	logic                 in_xfer;
	logic                 byte_xfer;
	logic                 tick_xfer;
	logic                 out_free;
	logic                 load_stat;
	logic                 load_chan;
	logic                 hdr_ok;
	logic                 data_byte_pos;
	logic                 frame_done;
	logic                 footer_ok;
	logic                 last_chan;

	sbfr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scl_req),
		.rsp    (scl_rsp)
	);

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		in_xfer       = s_tvalid && s_tready;
		byte_xfer     = in_xfer && (s_tuser == CMD_BYTE);
		tick_xfer     = in_xfer && (s_tuser == CMD_TICK);
		out_free      = !m_valid_q || m_tready;
		load_stat     = (state_q == ST_STAT) && out_free;
		load_chan     = (state_q == ST_CH_EMIT) && out_free;
		last_chan     = (ch_idx_q == IDX_W'(CHANNEL_COUNT - 1));
		hdr_ok        = (s_tdata == HEADER_BYTE) && ((now_q - end_q) > TIME_W'(gap_q));
		data_byte_pos = (byte_cnt_q >= CNT_W'(1)) && (byte_cnt_q <= CNT_W'(DATA_BYTES));
		frame_done    = in_frame_q && (byte_cnt_q == CNT_W'(FRAME_BYTES - 1));
		footer_ok     = frame_done && (s_tdata == FOOTER_BYTE);
		scl_req.start = (state_q == ST_CH_START);
		scl_req.raw   = chan_sr_q[CHAN_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_xfer) begin
					state_d = ST_TICK;
				end else if (byte_xfer && footer_ok) begin
					state_d = ST_CH_START;
				end
			end
			ST_TICK: state_d = ST_STAT;
			ST_STAT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CH_START: state_d = ST_CH_WAIT;
			ST_CH_WAIT: begin
				if (scl_rsp.done) begin
					state_d = ST_CH_EMIT;
				end
			end
			ST_CH_EMIT: begin
				if (out_free) begin
					state_d = last_chan ? ST_IDLE : ST_CH_START;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			byte_cnt_q <= '0;
			now_q      <= '0;
			start_q    <= '0;
			end_q      <= '0;
			gap_q      <= GAP_RESET;
			stuck_q    <= STUCK_RESET;
			rxto_q     <= RXTO_RESET;
			ch_idx_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_GAP:       gap_q   <= cfg_data[7:0];
					CFG_STUCK_TIMEOUT:   stuck_q <= cfg_data[7:0];
					CFG_RECEIVE_TIMEOUT: rxto_q  <= cfg_data;
					default:             ;
				endcase
			end

			if (tick_xfer) begin
				now_q <= now_q + TIME_W'(1);
			end
			if (state_q == ST_TICK && in_frame_q &&
			    ((now_q - start_q) > TIME_W'(stuck_q))) begin
				in_frame_q <= 1'b0;
			end

			if (byte_xfer) begin
				if (!in_frame_q) begin
					if (hdr_ok) begin
						in_frame_q <= 1'b1;
						byte_cnt_q <= CNT_W'(1);
						start_q    <= now_q;
					end
				end else if (frame_done) begin
					in_frame_q <= 1'b0;
					byte_cnt_q <= '0;
					if (footer_ok) begin
						end_q    <= now_q;
						ch_idx_q <= '0;
					end
				end else begin
					byte_cnt_q <= byte_cnt_q + CNT_W'(1);
				end
			end

			if (load_chan) begin
				ch_idx_q <= ch_idx_q + IDX_W'(1);
			end

			if (load_stat || load_chan) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer && in_frame_q && data_byte_pos) begin
			chan_sr_q <= {s_tdata, chan_sr_q[DATA_BITS-1:8]};
		end else if (load_chan) begin
			chan_sr_q <= {CHAN_BITS'(0), chan_sr_q[DATA_BITS-1:CHAN_BITS]};
		end

		if (load_stat) begin
			out_kind_q  <= KIND_STATUS;
			out_idx_q   <= '0;
			out_value_q <= '0;
			out_recv_q  <= ((now_q - end_q) <= TIME_W'(rxto_q));
			out_last_q  <= 1'b1;
		end else if (load_chan) begin
			out_kind_q  <= KIND_CHANNEL;
			out_idx_q   <= ch_idx_q;
			out_value_q <= scl_rsp.value;
			out_recv_q  <= 1'b1;
			out_last_q  <= last_chan;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {7'd0, out_recv_q, out_value_q, out_idx_q};
	assign m_tuser   = out_kind_q;
	assign m_tlast   = out_last_q;

	a_last_on_final_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_CHANNEL)) |-> (m_tlast == (m_tdata[3:0] == 4'd15)))
		else $error("tlast does not match the final channel");

	a_channel_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_CHANNEL)) |->
		((m_tdata[15:4] >= 12'd883) && (m_tdata[15:4] <= 12'd2156)))
		else $error("scaled channel value out of range");

	a_status_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_STATUS)) |-> (m_tdata[15:0] == 16'd0) && m_tlast)
		else $error("status result carries channel data");

	a_scale_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		scl_rsp.done |-> (state_q == ST_CH_WAIT))
		else $error("scaler finished outside a channel wait");

	a_byte_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (byte_cnt_q < CNT_W'(FRAME_BYTES)) && (byte_cnt_q != '0))
		else $error("frame byte count out of range");

endmodule

>>> sim/sbus_frame_receiver_tb.sv
module sbus_frame_receiver_tb;
	import sbfr_pkg::*;

	typedef struct {
		logic               kind;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] value;
		logic               rx_ok;
		logic               tlast;
	} rx_result_t;

	class frame_scoreboard;
		logic [7:0]  gap_ms;
		logic [7:0]  stuck_ms;
		logic [15:0] rxto_ms;
		logic        in_frame;
		int          byte_count;
		logic [7:0]  frame_buf [FRAME_BYTES];
		logic [31:0] now_ms;
		logic [31:0] frame_start_ms;
		logic [31:0] frame_end_ms;
		rx_result_t  due_q [$];
		int          errors;
		int          n_in;
		int          n_good;
		int          n_dropped;
		int          n_status;

		function new();
			gap_ms = GAP_RESET;
			stuck_ms = STUCK_RESET;
			rxto_ms = RXTO_RESET;
			in_frame = 1'b0;
			byte_count = 0;
			now_ms = '0;
			frame_start_ms = '0;
			frame_end_ms = '0;
			errors = 0;
			n_in = 0;
			n_good = 0;
			n_dropped = 0;
			n_status = 0;
		endfunction

		function void write_reg(cfg_index_t i, logic [15:0] v);
			case (i)
				CFG_START_GAP: gap_ms = v[7:0];
				CFG_STUCK_TIMEOUT: stuck_ms = v[7:0];
				CFG_RECEIVE_TIMEOUT: rxto_ms = v;
				default: ;
			endcase
		endfunction

		function logic still_receiving();
			logic [31:0] el;
			el = now_ms - frame_end_ms;
			return el <= 32'(rxto_ms);
		endfunction

		function logic [VALUE_W-1:0] scale_us(logic [CHAN_BITS-1:0] v);
			int d;
			d = (int'(v) - int'(CHAN_OFFSET)) * int'(SCALE_MUL);
			return VALUE_W'(d / int'(SCALE_DIV) + int'(CHAN_CENTER));
		endfunction

		function void note_transfer(logic cmd, logic [7:0] b);
			logic [31:0]              el;
			logic [8*FRAME_BYTES-1:0] flat;
			rx_result_t               r;
			n_in++;
			if (cmd == CMD_TICK) begin
				now_ms = now_ms + 1;
				el = now_ms - frame_start_ms;
				if (in_frame && el > 32'(stuck_ms))
					in_frame = 1'b0;
				r.kind = KIND_STATUS;
				r.idx = '0;
				r.value = '0;
				r.rx_ok = still_receiving();
				r.tlast = 1'b1;
				due_q.push_back(r);
				n_status++;
				return;
			end
			el = now_ms - frame_end_ms;
			if (!in_frame) begin
				if (b != HEADER_BYTE || el <= 32'(gap_ms))
					return;
				frame_start_ms = now_ms;
				byte_count = 0;
				in_frame = 1'b1;
			end
			frame_buf[byte_count] = b;
			byte_count++;
			if (byte_count < FRAME_BYTES)
				return;
			in_frame = 1'b0;
			byte_count = 0;
			if (frame_buf[FRAME_BYTES-1] != FOOTER_BYTE) begin
				n_dropped++;
				return;
			end
			frame_end_ms = now_ms;
			n_good++;
			for (int i = 0; i < FRAME_BYTES; i++)
				flat[8*i +: 8] = frame_buf[i];
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				r.kind = KIND_CHANNEL;
				r.idx = IDX_W'(c);
				r.value = scale_us(flat[8 + CHAN_BITS*c +: CHAN_BITS]);
				r.rx_ok = still_receiving();
				r.tlast = (c == CHANNEL_COUNT - 1);
				due_q.push_back(r);
			end
		endfunction

		function void cmp(string what, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_transfer(logic [23:0] d, logic u, logic l);
			rx_result_t e;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
					$time, d, u, l);
				errors++;
				return;
			end
			e = due_q.pop_front();
			cmp("kind", e.kind, u);
			cmp("channel_index", e.idx, d[3:0]);
			cmp("channel_value", e.value, d[15:4]);
			cmp("receiving", e.rx_ok, d[16]);
			cmp("tdata padding", 0, d[23:17]);
			cmp("tlast", e.tlast, l);
		endfunction
	endclass

	localparam int HOLD_CYCLES = 400;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [23:0]            m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_scoreboard      sb;
	bit                   jitter_on = 1'b1;
	bit                   hold_req = 1'b0;
	int                   hold_left = 0;
	logic [CHAN_BITS-1:0] chan_set [CHANNEL_COUNT];

	sbus_frame_receiver u_top (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.s_tuser,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tuser,
		.m_tlast,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = !(jitter_on && $urandom_range(0, 99) < 11);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_transfer(m_tdata, m_tuser, m_tlast);
	end

	task automatic push(input logic cmd, input logic [7:0] b);
		while (jitter_on && $urandom_range(0, 99) < 11) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		sb.note_transfer(cmd, b);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic ticks(input int n);
		repeat (n) push(CMD_TICK, 8'($urandom));
	endtask

	task automatic prepare_header();
		while (sb.in_frame)
			push(CMD_BYTE, 8'($urandom));
		while ((sb.now_ms - sb.frame_end_ms) <= 32'(sb.gap_ms))
			push(CMD_TICK, 8'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] footer, input int tick_pct);
		logic [8*FRAME_BYTES-1:0] flat;
		flat = '0;
		flat[7:0] = HEADER_BYTE;
		for (int c = 0; c < CHANNEL_COUNT; c++)
			flat[8 + CHAN_BITS*c +: CHAN_BITS] = chan_set[c];
		flat[8*(FRAME_BYTES-2) +: 8] = 8'($urandom);
		flat[8*(FRAME_BYTES-1) +: 8] = footer;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (i > 0 && $urandom_range(0, 99) < tick_pct)
				push(CMD_TICK, 8'($urandom));
			push(CMD_BYTE, flat[8*i +: 8]);
		end
	endtask

	task automatic rand_chans();
		for (int c = 0; c < CHANNEL_COUNT; c++) begin
			case ($urandom_range(0, 7))
				0: chan_set[c] = '0;
				1: chan_set[c] = '1;
				2: chan_set[c] = CHAN_BITS'(int'(CHAN_OFFSET) + $urandom_range(0, 2) - 1);
				default: chan_set[c] = CHAN_BITS'($urandom);
			endcase
		end
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.due_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic wr_reg(input cfg_index_t i, input logic [15:0] v);
		cfg_valid = 1'b1;
		cfg_index = i;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(i, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_episode();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			prepare_header();
			rand_chans();
			send_frame(($urandom_range(0, 99) < 85) ? FOOTER_BYTE : 8'($urandom_range(1, 255)),
				($urandom_range(0, 3) == 0) ? 6 : 0);
			ticks($urandom_range(0, 3));
		end else if (r < 82) begin
			repeat ($urandom_range(4, 12))
				push(($urandom_range(0, 3) == 0) ? CMD_TICK : CMD_BYTE,
					($urandom_range(0, 4) == 0) ? HEADER_BYTE : 8'($urandom));
		end else begin
			prepare_header();
			push(CMD_BYTE, HEADER_BYTE);
			repeat ($urandom_range(1, 22))
				push(CMD_BYTE, 8'($urandom));
			k = int'(sb.stuck_ms) + 2;
			if (k > 14)
				k = 3;
			ticks(k);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_BYTE;
		m_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = CFG_START_GAP;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		ticks(6);
		push(CMD_BYTE, 8'hA5);
		chan_set = '{11'd0, 11'd2047, 11'd172, 11'd173, 11'd174, 11'd1811, 11'd1, 11'd2046,
			11'd992, 11'd1024, 11'd1000, 11'd500, 11'd1500, 11'h555, 11'h2AA, 11'd1638};
		send_frame(FOOTER_BYTE, 0);
		push(CMD_BYTE, HEADER_BYTE);
		ticks(1);
		repeat (3) random_episode();
		settle();

		wr_reg(CFG_START_GAP, 16'd0);
		wr_reg(CFG_STUCK_TIMEOUT, 16'd0);
		wr_reg(CFG_RECEIVE_TIMEOUT, 16'd0);
		jitter_on = 1'b0;
		repeat (3) random_episode();
		settle();
		jitter_on = 1'b1;

		wr_reg(CFG_START_GAP, 16'($urandom_range(1, 8)));
		wr_reg(CFG_STUCK_TIMEOUT, 16'd30);
		wr_reg(CFG_RECEIVE_TIMEOUT, 16'($urandom_range(2, 40)));
		hold_req = 1'b1;
		repeat (2) begin
			prepare_header();
			rand_chans();
			send_frame(FOOTER_BYTE, 0);
		end
		settle();

		wr_reg(CFG_START_GAP, 16'd255);
		wr_reg(CFG_STUCK_TIMEOUT, 16'd255);
		wr_reg(CFG_RECEIVE_TIMEOUT, 16'hFFFF);
		push(CMD_BYTE, HEADER_BYTE);
		ticks(3);
		settle();
		wr_reg(CFG_START_GAP, 16'd2);
		prepare_header();
		rand_chans();
		send_frame(FOOTER_BYTE, 10);
		push(CMD_BYTE, HEADER_BYTE);
		ticks(2);
		settle();

		repeat (2) begin
			wr_reg(CFG_START_GAP, 16'($urandom_range(0, 12)));
			wr_reg(CFG_STUCK_TIMEOUT, 16'($urandom_range(0, 40)));
			wr_reg(CFG_RECEIVE_TIMEOUT,
				($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 400)));
			repeat (2) random_episode();
			settle();
		end

		$display("Covered %0d inputs: %0d good frames, %0d dropped frames, %0d status reports.",
			sb.n_in, sb.n_good, sb.n_dropped, sb.n_status);
		$display("Registers ranged from all zeros to all ones, with a long output hold-off; %0d mismatches.",
			sb.errors);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sbus_frame_receiver.f
rtl/core/sbfr_pkg.sv
rtl/core/sbfr_scale.sv
rtl/core/sbus_frame_receiver.sv
sim/sbus_frame_receiver_tb.sv
